FILE: rtl/modified_utf8_to_utf16_decoder_macros.svh
// Assertion macros used by the decoder's output queue.
`ifndef MODIFIED_UTF8_TO_UTF16_DECODER_MACROS_SVH
`define MODIFIED_UTF8_TO_UTF16_DECODER_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define MUTF8_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define MUTF8_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/mutf8_pkg.sv
// Types and constants shared by the modified UTF-8 decoder modules.
package mutf8_pkg;

   localparam logic [7:0]  CONT_MASK     = 8'hC0;
   localparam logic [7:0]  CONT_TAG      = 8'h80;
   localparam logic [7:0]  LEAD_THREE    = 8'hE0;
   localparam logic [7:0]  LEAD_FOUR     = 8'hF0;
   localparam logic [15:0] CHAR_QUESTION = 16'h003F;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_ONE  = 3'b010,
      PH_TWO  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [15:0] code;
      logic        run_last;
      logic        text_last;
   } result_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] lead_byte;
      logic [5:0] second_bits;
   } state_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
      state_type  next_state;
   } decode_type;

endpackage

FILE: rtl/modified_utf8_to_utf16_decoder.sv
// Top level of the modified UTF-8 to UTF-16 stream decoder.
// One byte beat enters per cycle while the queue has room for the held byte's
// results; a byte is registered in a hold register, decoded from it, and
// gives zero, one or two 16-bit character beats. The decoded results go
// through a two-entry output queue, so the input side keeps taking one byte
// per cycle while the output takes one beat per cycle; a byte that gives two
// results (a broken sequence followed by ASCII, or by a lead byte at text end)
// may stall the input until the queue has room for both of its results.
module modified_utf8_to_utf16_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] char_code
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // [0] text_last
);

   logic                  hold_valid_ff;
   logic [7:0]            hold_byte_ff;
   logic                  hold_eot_ff;
   logic                  process;
   logic [1:0]            space;
   mutf8_pkg::state_type  state_ff;
   mutf8_pkg::decode_type decoded;
   mutf8_pkg::result_type head;

   mutf8_decode u_decode (
      .state       (state_ff),
      .in_byte     (hold_byte_ff),
      .end_of_text (hold_eot_ff),
      .result      (decoded)
   );

   assign process = hold_valid_ff && (decoded.count <= space);
   assign req_tready = !hold_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         state_ff.phase <= mutf8_pkg::PH_IDLE;
         state_ff.lead_byte <= 8'h00;
         state_ff.second_bits <= 6'h00;
      end else begin
         if (req_tready) begin
            hold_valid_ff <= req_tvalid;
         end
         if (process) begin
            state_ff <= decoded.next_state;
         end
      end
      if (req_tready && req_tvalid) begin
         hold_byte_ff <= req_tdata;
         hold_eot_ff <= req_tlast;
      end
   end

   mutf8_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (process),
      .push_count  (decoded.count),
      .push_first  (decoded.first),
      .push_second (decoded.second),
      .space       (space),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_head    (head)
   );

   assign rsp_tdata = head.code;
   assign rsp_tlast = head.run_last;
   assign rsp_tuser = head.text_last;

endmodule

FILE: rtl/mutf8_decode.sv
// Combinational decode of one byte against the pending sequence state.
module mutf8_decode (
   input  mutf8_pkg::state_type  state,
   input  logic [7:0]            in_byte,
   input  logic                  end_of_text,
   output mutf8_pkg::decode_type result
);

   logic        is_cont;
   logic        take_lead;
   logic [1:0]  n;
   logic [15:0] code0;
   logic [15:0] code1;
   mutf8_pkg::state_type nxt;

   assign is_cont = (in_byte & mutf8_pkg::CONT_MASK) == mutf8_pkg::CONT_TAG;

   always_comb begin
      n = 2'd0;
      code0 = mutf8_pkg::CHAR_QUESTION;
      code1 = mutf8_pkg::CHAR_QUESTION;
      take_lead = 1'b1;
      nxt = state;
      unique case (state.phase)
         mutf8_pkg::PH_ONE: begin
            if (is_cont) begin
               take_lead = 1'b0;
               if (state.lead_byte < mutf8_pkg::LEAD_THREE) begin
                  code0 = {5'b0, state.lead_byte[4:0], in_byte[5:0]};
                  n = 2'd1;
                  nxt.phase = mutf8_pkg::PH_IDLE;
               end else begin
                  nxt.second_bits = in_byte[5:0];
                  nxt.phase = mutf8_pkg::PH_TWO;
               end
            end else begin
               n = 2'd1;
               nxt.phase = mutf8_pkg::PH_IDLE;
            end
         end
         mutf8_pkg::PH_TWO: begin
            if (is_cont) begin
               take_lead = 1'b0;
               if (state.lead_byte < mutf8_pkg::LEAD_FOUR) begin
                  code0 = {state.lead_byte[3:0], state.second_bits, in_byte[5:0]};
               end
            end
            n = 2'd1;
            nxt.phase = mutf8_pkg::PH_IDLE;
         end
         default: begin
            nxt.phase = mutf8_pkg::PH_IDLE;
         end
      endcase

      if (take_lead) begin
         if (!in_byte[7]) begin
            if (n == 2'd0) begin
               code0 = {8'b0, in_byte};
            end else begin
               code1 = {8'b0, in_byte};
            end
            n = n + 2'd1;
         end else begin
            nxt.lead_byte = in_byte;
            nxt.phase = mutf8_pkg::PH_ONE;
         end
      end

      if (end_of_text && nxt.phase != mutf8_pkg::PH_IDLE) begin
         if (n == 2'd0) begin
            code0 = mutf8_pkg::CHAR_QUESTION;
         end else begin
            code1 = mutf8_pkg::CHAR_QUESTION;
         end
         n = n + 2'd1;
         nxt.phase = mutf8_pkg::PH_IDLE;
      end
   end

   assign result.count = n;
   assign result.first.code = code0;
   assign result.first.run_last = (n == 2'd1);
   assign result.first.text_last = (n == 2'd1) && end_of_text;
   assign result.second.code = code1;
   assign result.second.run_last = 1'b1;
   assign result.second.text_last = end_of_text;
   assign result.next_state = nxt;

endmodule

FILE: rtl/mutf8_out_queue.sv
// Two-entry result queue that takes up to two results and gives one per beat.
`include "modified_utf8_to_utf16_decoder_macros.svh"

module mutf8_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [1:0]             push_count,
   input  mutf8_pkg::result_type  push_first,
   input  mutf8_pkg::result_type  push_second,
   output logic [1:0]             space,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output mutf8_pkg::result_type  rsp_head
);

   logic [1:0]            count_ff;
   logic [1:0]            count_in;
   logic [1:0]            count_after_pop;
   logic                  pop;
   mutf8_pkg::result_type entry0_ff;
   mutf8_pkg::result_type entry1_ff;
   mutf8_pkg::result_type entry0_in;
   mutf8_pkg::result_type entry1_in;

   assign pop = (count_ff != 2'd0) && rsp_tready;
   assign count_after_pop = count_ff - {1'b0, pop};
   assign space = 2'd2 - count_after_pop;

   always_comb begin
      entry0_in = pop ? entry1_ff : entry0_ff;
      entry1_in = entry1_ff;
      count_in = count_after_pop;
      if (push) begin
         if (push_count != 2'd0) begin
            if (count_after_pop == 2'd0) begin
               entry0_in = push_first;
            end else begin
               entry1_in = push_first;
            end
         end
         if (push_count == 2'd2) begin
            entry1_in = push_second;
         end
         count_in = count_after_pop + push_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_head = entry0_ff;

   `MUTF8_ASSERT_ALWAYS(a_count_max, clock, reset, count_ff != 2'd3, "queue count out of range")
   `MUTF8_ASSERT_ALWAYS(a_no_overflow, clock, reset, !push || push_count <= space, "queue overflow")
   `MUTF8_ASSERT_NEXT(a_pop_only, clock, reset, pop && !push, count_ff == $past(count_ff) - 2'd1, "pop count")

endmodule

FILE: tb/sv/modified_utf8_to_utf16_decoder_test.sv
// Self-checking stream testbench for the modified UTF-8 to UTF-16 decoder.
module modified_utf8_to_utf16_decoder_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 10;
   localparam int STALL_LIMIT  = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tlast;   // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] char_code
   logic        rsp_tlast;   // run_last
   logic        rsp_tuser;   // [0] text_last

   mutf8_pkg::result_type expected_chars[$];
   mutf8_pkg::phase_type  seq_phase;
   logic [7:0]            seq_lead;
   logic [5:0]            seq_second;
   int                    errors = 0;
   int                    bytes_sent = 0;
   int                    stall_count = 0;
   bit                    quiet = 1'b0;
   bit                    hold_request = 1'b0;

   modified_utf8_to_utf16_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] cont_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 63));
      return mutf8_pkg::CONT_TAG | b;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic eot);
      logic [15:0]           codes[2];
      mutf8_pkg::result_type r;
      int                    n;
      bit                    as_lead;
      n = 0;
      as_lead = 1'b1;
      unique case (seq_phase)
         mutf8_pkg::PH_ONE: begin
            if ((b & mutf8_pkg::CONT_MASK) == mutf8_pkg::CONT_TAG) begin
               as_lead = 1'b0;
               if (seq_lead < mutf8_pkg::LEAD_THREE) begin
                  codes[n] = {5'b00000, seq_lead[4:0], b[5:0]};
                  n++;
                  seq_phase = mutf8_pkg::PH_IDLE;
               end else begin
                  seq_second = b[5:0];
                  seq_phase = mutf8_pkg::PH_TWO;
               end
            end else begin
               codes[n] = mutf8_pkg::CHAR_QUESTION;
               n++;
               seq_phase = mutf8_pkg::PH_IDLE;
            end
         end
         mutf8_pkg::PH_TWO: begin
            if ((b & mutf8_pkg::CONT_MASK) == mutf8_pkg::CONT_TAG) begin
               as_lead = 1'b0;
               if (seq_lead < mutf8_pkg::LEAD_FOUR) begin
                  codes[n] = {seq_lead[3:0], seq_second, b[5:0]};
               end else begin
                  codes[n] = mutf8_pkg::CHAR_QUESTION;
               end
               n++;
            end else begin
               codes[n] = mutf8_pkg::CHAR_QUESTION;
               n++;
            end
            seq_phase = mutf8_pkg::PH_IDLE;
         end
         default: seq_phase = mutf8_pkg::PH_IDLE;
      endcase
      if (as_lead) begin
         if (b < mutf8_pkg::CONT_TAG) begin
            codes[n] = {8'h00, b};
            n++;
         end else begin
            seq_lead = b;
            seq_phase = mutf8_pkg::PH_ONE;
         end
      end
      if (eot && seq_phase != mutf8_pkg::PH_IDLE) begin
         codes[n] = mutf8_pkg::CHAR_QUESTION;
         n++;
         seq_phase = mutf8_pkg::PH_IDLE;
      end
      for (int i = 0; i < n; i++) begin
         r.code = codes[i];
         r.run_last = (i == n - 1);
         r.text_last = (i == n - 1) && eot;
         expected_chars.push_back(r);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eot);
      int gap;
      bit ok;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eot;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
      decode_byte(b, eot);
      bytes_sent++;
   endtask

   task automatic send_char(input bit finish);
      logic [7:0] seq[3];
      int         len;
      int         kind;
      kind = $urandom_range(0, 99);
      seq[0] = 8'($urandom_range(0, 255));
      seq[1] = cont_byte();
      seq[2] = cont_byte();
      if (kind < 35) begin
         seq[0] = 8'($urandom_range(0, 127));
         len = 1;
      end else if (kind < 60) begin
         seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
         len = 2;
      end else if (kind < 65) begin
         seq[0] = 8'($urandom_range(8'h80, 8'hBF));
         len = 2;
      end else if (kind < 83) begin
         seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
         len = 3;
      end else if (kind < 88) begin
         seq[0] = 8'($urandom_range(8'hF0, 8'hFF));
         len = 3;
      end else if (kind < 94) begin
         seq[0] = 8'($urandom_range(8'hC0, 8'hEF));
         seq[1] = 8'($urandom_range(0, 255));
         len = $urandom_range(1, 2);
      end else begin
         seq[1] = 8'($urandom_range(0, 255));
         seq[2] = 8'($urandom_range(0, 255));
         len = $urandom_range(1, 3);
      end
      for (int i = 0; i < len; i++) send_byte(seq[i], finish && (i == len - 1));
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_chars.size() != 0);
   endtask

   task automatic test_directed();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hE0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hC3, 1'b1);
      send_byte(8'h41, 1'b1);
      send_byte(8'hE2, 1'b1);
   endtask

   task automatic test_random_text();
      int stop_at;
      stop_at = bytes_sent + 1000;
      while (bytes_sent < stop_at) send_char($urandom_range(0, 19) == 0);
   endtask

   task automatic test_backpressure();
      int stop_at;
      quiet = 1'b1;
      hold_request = 1'b1;
      stop_at = bytes_sent + 60;
      while (bytes_sent < stop_at) send_char($urandom_range(0, 29) == 0);
      quiet = 1'b0;
   endtask

   task automatic test_unbroken();
      int stop_at;
      quiet = 1'b1;
      stop_at = bytes_sent + 200;
      while (bytes_sent < stop_at) send_char($urandom_range(0, 19) == 0);
      quiet = 1'b0;
   endtask

   initial begin
      int on_cycles;
      int gap;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         on_cycles = $urandom_range(1, 12);
         repeat (on_cycles) @(posedge clock);
      end
   end

   always @(negedge clock) begin
      mutf8_pkg::result_type want;
      mutf8_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.code = rsp_tdata;
         got.run_last = rsp_tlast;
         got.text_last = rsp_tuser;
         if (expected_chars.size() == 0) begin
            $display("%0t: char beat expected none got %h run_last %b text_last %b", $time,
               got.code, got.run_last, got.text_last);
            errors++;
         end else begin
            want = expected_chars.pop_front();
            if (got.code !== want.code) begin
               $display("%0t: char_code expected %h got %h", $time, want.code, got.code);
               errors++;
            end
            if (got.run_last !== want.run_last) begin
               $display("%0t: run_last expected %b got %b", $time, want.run_last,
                  got.run_last);
               errors++;
            end
            if (got.text_last !== want.text_last) begin
               $display("%0t: text_last expected %b got %b", $time, want.text_last,
                  got.text_last);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_count = 0;
      else stall_count++;
      if (stall_count >= STALL_LIMIT) begin
         $display("modified_utf8_to_utf16_decoder_test: errors");
         $finish;
      end
   end

   initial begin
      seq_phase = mutf8_pkg::PH_IDLE;
      seq_lead = 8'h00;
      seq_second = 6'h00;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      req_tlast <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drain();
      test_random_text();
      wait_drain();
      test_backpressure();
      wait_drain();
      test_unbroken();
      wait_drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && expected_chars.size() == 0) begin
         $display("modified_utf8_to_utf16_decoder_test: clean");
      end else begin
         $display("modified_utf8_to_utf16_decoder_test: errors");
      end
      $finish;
   end

endmodule
